[rtl/jet_pkg.sv]
package jet_pkg;

	localparam int FRAC_BITS = 28;
	localparam int ADDR_WIDTH = 5;

	// register indexes, byte address = 4 * index
	localparam logic [2:0] REG_C_REAL     = 3'd0;
	localparam logic [2:0] REG_C_IMAG     = 3'd1;
	localparam logic [2:0] REG_PLANE_LEFT = 3'd2;
	localparam logic [2:0] REG_PLANE_TOP  = 3'd3;
	localparam logic [2:0] REG_STEP_X     = 3'd4;
	localparam logic [2:0] REG_STEP_Y     = 3'd5;
	localparam logic [2:0] REG_MAX_COUNT  = 3'd6;
	localparam logic [2:0] REG_GRID_DIMS  = 3'd7;

	localparam logic signed [30:0] RST_C_REAL     = -31'sd174615117;
	localparam logic signed [30:0] RST_C_IMAG     = -31'sd128375230;
	localparam logic signed [30:0] RST_PLANE_LEFT = -31'sd402653184;
	localparam logic signed [30:0] RST_PLANE_TOP  = 31'sd268435456;
	localparam logic [29:0]        RST_STEP_X     = 30'd2684355;
	localparam logic [29:0]        RST_STEP_Y     = 30'd2684355;
	localparam logic [11:0]        RST_MAX_COUNT  = 12'd255;
	localparam logic [23:0]        RST_GRID_DIMS  = 24'd819500;

	localparam logic [12:0] ESC_OUTSIDE = 13'h1FFF;

	typedef struct packed {
		logic signed [30:0] c_real;
		logic signed [30:0] c_imag;
		logic signed [30:0] plane_left;
		logic signed [30:0] plane_top;
		logic [29:0]        step_x;
		logic [29:0]        step_y;
		logic [11:0]        max_count;
		logic [23:0]        grid_dims;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic map;
		logic init;
		logic mul;
		logic step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic outside;
		logic cont;
	} dp_status_t;

endpackage

[rtl/julia_escape_time_pixel_top.sv]
// channel  dir  signals                          payload
// s_       in   s_tvalid s_tready s_tdata[23:0]  pixel_row, pixel_column
// m_       out  m_tvalid m_tready m_tdata[15:0]  escape_count (13 bit signed)
// cfg      in   APB psel penable pwrite paddr[4:0] pwdata prdata pready
//
// Each request runs load, map and init, then the iteration loop (multiply step,
// then add/saturate step) through the shared datapath, then done; a pixel outside
// the grid goes from map straight to done.
// Reset: arst_n asynchronous, registers back to their reset values, no result pending.
// A new request is taken once the previous result sits in the output register;
// a stalled output holds its value and holds the block in its done state.
module julia_escape_time_pixel_top
	import jet_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [11:0] pixel_row, [23:12] pixel_column
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [12:0] escape_count, [15:13] zero
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t st;
	logic [12:0] escape_count;

	assign pready  = 1'b1;
	assign m_tdata = {3'b000, escape_count};

	jet_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	jet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	jet_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.pixel_row    (s_tdata[11:0]),
		.pixel_column (s_tdata[23:12]),
		.st           (st),
		.escape_count (escape_count)
	);

endmodule

[rtl/jet_regs.sv]
module jet_regs
	import jet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real     <= RST_C_REAL;
			cfg_q.c_imag     <= RST_C_IMAG;
			cfg_q.plane_left <= RST_PLANE_LEFT;
			cfg_q.plane_top  <= RST_PLANE_TOP;
			cfg_q.step_x     <= RST_STEP_X;
			cfg_q.step_y     <= RST_STEP_Y;
			cfg_q.max_count  <= RST_MAX_COUNT;
			cfg_q.grid_dims  <= RST_GRID_DIMS;
		end else if (wr_en) begin
			case (idx)
				REG_C_REAL:     cfg_q.c_real     <= signed'(pwdata[30:0]);
				REG_C_IMAG:     cfg_q.c_imag     <= signed'(pwdata[30:0]);
				REG_PLANE_LEFT: cfg_q.plane_left <= signed'(pwdata[30:0]);
				REG_PLANE_TOP:  cfg_q.plane_top  <= signed'(pwdata[30:0]);
				REG_STEP_X:     cfg_q.step_x     <= pwdata[29:0];
				REG_STEP_Y:     cfg_q.step_y     <= pwdata[29:0];
				REG_MAX_COUNT:  cfg_q.max_count  <= pwdata[11:0];
				REG_GRID_DIMS:  cfg_q.grid_dims  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_C_REAL:     prdata = 32'(cfg_q.c_real);
			REG_C_IMAG:     prdata = 32'(cfg_q.c_imag);
			REG_PLANE_LEFT: prdata = 32'(cfg_q.plane_left);
			REG_PLANE_TOP:  prdata = 32'(cfg_q.plane_top);
			REG_STEP_X:     prdata = {2'b00, cfg_q.step_x};
			REG_STEP_Y:     prdata = {2'b00, cfg_q.step_y};
			REG_MAX_COUNT:  prdata = {20'd0, cfg_q.max_count};
			REG_GRID_DIMS:  prdata = {8'd0, cfg_q.grid_dims};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

[rtl/jet_dp.sv]
module jet_dp
	import jet_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	input  logic [11:0] pixel_row,
	input  logic [11:0] pixel_column,
	output dp_status_t  st,
	output logic [12:0] escape_count
);

	localparam int W = COORD_WIDTH;
	localparam int CW = COUNT_WIDTH;
	// working width: holds full products, their sum and the 2^58 radius bound
	localparam int PW = (2 * W + 2 > 62) ? 2 * W + 2 : 62;
	localparam int LW = (CW > 12) ? CW : 12;
	localparam int CXW = (CW > 13) ? CW : 13;

	localparam logic signed [PW-1:0] SAT_HI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [PW-1:0] RAD    = signed'(PW'(1) << (FRAC_BITS + 1));
	localparam logic signed [PW-1:0] RAD2   = signed'(PW'(1) << (2 * FRAC_BITS + 2));
	localparam logic [LW-1:0]        CMAX   = LW'((64'd1 << CW) - 64'd1);

	function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
		logic signed [W-1:0] r;
		if (v > SAT_HI) r = SAT_HI[W-1:0];
		else if (v < SAT_LO) r = SAT_LO[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	logic [11:0]          row_q, col_q;
	logic                 outside_q;
	logic [41:0]          mx_q, my_q;
	logic signed [W-1:0]  x_q, y_q;
	logic [CW-1:0]        count_q;
	logic signed [2*W-1:0] xx_q, yy_q, xy_q;
	logic                 bound_q;
	logic [12:0]          result_q;

	logic [11:0]          height, width;
	logic [LW-1:0]        mc_e;
	logic [CW-1:0]        limit;
	logic signed [W-1:0]  cr_w, ci_w;
	logic signed [PW-1:0] cre, cie, xe, ye, xxe, yye, xye, mag;
	logic signed [PW-1:0] map_x, map_y, nx_full, ny_full;
	logic                 in_radius;
	logic [CXW-1:0]       cnt_e;

	assign height = cfg.grid_dims[23:12];
	assign width  = cfg.grid_dims[11:0];
	assign mc_e   = LW'(cfg.max_count);
	assign limit  = (mc_e > CMAX) ? CMAX[CW-1:0] : mc_e[CW-1:0];

	assign cr_w = sat_w(PW'(cfg.c_real));
	assign ci_w = sat_w(PW'(cfg.c_imag));
	assign cre  = PW'(cr_w);
	assign cie  = PW'(ci_w);

	assign map_x = PW'(cfg.plane_left) + signed'({{(PW-42){1'b0}}, mx_q});
	assign map_y = PW'(cfg.plane_top) - signed'({{(PW-42){1'b0}}, my_q});

	assign xe  = PW'(x_q);
	assign ye  = PW'(y_q);
	assign xxe = PW'(xx_q);
	assign yye = PW'(yy_q);
	assign xye = PW'(xy_q);
	assign mag = xxe + yye;
	assign in_radius = bound_q && (mag <= RAD2);

	// products carry 56 fraction bits; >>> floors back to 28
	assign nx_full = ((xxe - yye) >>> FRAC_BITS) + cre;
	assign ny_full = ((xye <<< 1) >>> FRAC_BITS) + cie;

	assign cnt_e = CXW'(count_q);

	assign st.outside = outside_q;
	assign st.cont    = in_radius && (count_q < limit);
	assign escape_count = result_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q     <= pixel_row;
			col_q     <= pixel_column;
			outside_q <= (pixel_row >= height) || (pixel_column >= width);
		end
		if (cmd.map) begin
			mx_q <= col_q * cfg.step_x;
			my_q <= row_q * cfg.step_y;
		end
		if (cmd.mul) begin
			xx_q    <= x_q * x_q;
			yy_q    <= y_q * y_q;
			xy_q    <= x_q * y_q;
			bound_q <= (xe <= RAD) && (xe >= -RAD) && (ye <= RAD) && (ye >= -RAD);
		end
		if (cmd.emit) begin
			result_q <= outside_q ? ESC_OUTSIDE : cnt_e[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			count_q <= '0;
		end else if (cmd.init) begin
			x_q     <= sat_w(map_x);
			y_q     <= sat_w(map_y);
			count_q <= '0;
		end else if (cmd.step) begin
			x_q     <= sat_w(nx_full);
			y_q     <= sat_w(ny_full);
			count_q <= count_q + 1'b1;
		end
	end

	a_step_in_radius: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> in_radius)
		else $error("iteration step taken outside escape radius");

	a_step_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (count_q < limit))
		else $error("iteration step taken at count limit");

	a_step_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (count_q == $past(count_q) + 1'b1))
		else $error("count did not advance on step");

endmodule

[rtl/jet_ctrl.sv]
module jet_ctrl
	import jet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAP  = 3'd1;
	localparam logic [2:0] ST_INIT = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = st.outside ? ST_DONE : ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (st.cont) begin
					cmd.step = 1'b1;
					state_d = ST_MUL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait until the output register can take the result
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	a_accept_to_map: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MAP))
		else $error("accepted request did not start mapping");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result overwrote a pending output");

endmodule

[test/tb_julia_escape_time_pixel_top.sv]
module tb_julia_escape_time_pixel_top;
	import jet_pkg::*;

	localparam int COORD_W = 32;
	localparam int HOLD_CYCLES = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;   // [11:0] pixel_row, [23:12] pixel_column
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;        // [12:0] escape_count, [15:13] zero
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	julia_escape_time_pixel_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cfg_t view_cfg;
	logic [12:0] escape_q[$];
	longint orbit_real;
	longint orbit_imag;
	int orbit_count;
	int err_count = 0;
	bit src_idle_en = 1'b0;
	bit sink_idle_en = 1'b0;
	int hold_asked = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic longint clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// |z| <= 2, exact on the full-width squares
	function automatic bit in_disk(input longint x, input longint y);
		longint lim;
		lim = longint'(2) <<< FRAC_BITS;
		if (x > lim || x < -lim || y > lim || y < -lim) return 1'b0;
		return (x * x + y * y) <= (longint'(4) <<< (2 * FRAC_BITS));
	endfunction

	function automatic logic [12:0] predict_escape(input logic [11:0] row, input logic [11:0] col);
		longint x;
		longint y;
		longint cr;
		longint ci;
		longint nx;
		longint ny;
		int count;
		if (row >= view_cfg.grid_dims[23:12] || col >= view_cfg.grid_dims[11:0])
			return ESC_OUTSIDE;
		cr = clamp_coord(longint'($signed(view_cfg.c_real)));
		ci = clamp_coord(longint'($signed(view_cfg.c_imag)));
		x = clamp_coord(longint'($signed(view_cfg.plane_left))
			+ longint'(col) * longint'(view_cfg.step_x));
		y = clamp_coord(longint'($signed(view_cfg.plane_top))
			- longint'(row) * longint'(view_cfg.step_y));
		count = 0;
		while (count < int'(view_cfg.max_count) && in_disk(x, y)) begin
			// products back to 28 fraction bits, rounding toward minus infinity
			nx = clamp_coord(((x * x - y * y) >>> FRAC_BITS) + cr);
			ny = clamp_coord(((longint'(2) * x * y) >>> FRAC_BITS) + ci);
			x = nx;
			y = ny;
			count++;
		end
		orbit_real = x;
		orbit_imag = y;
		orbit_count = count;
		return 13'(count);
	endfunction

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_C_REAL:     view_cfg.c_real = val[30:0];
			REG_C_IMAG:     view_cfg.c_imag = val[30:0];
			REG_PLANE_LEFT: view_cfg.plane_left = val[30:0];
			REG_PLANE_TOP:  view_cfg.plane_top = val[30:0];
			REG_STEP_X:     view_cfg.step_x = val[29:0];
			REG_STEP_Y:     view_cfg.step_y = val[29:0];
			REG_MAX_COUNT:  view_cfg.max_count = val[11:0];
			REG_GRID_DIMS:  view_cfg.grid_dims = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] cr, input logic [31:0] ci,
		input logic [31:0] left, input logic [31:0] top, input logic [31:0] sx,
		input logic [31:0] sy, input logic [31:0] mc, input logic [31:0] dims);
		apb_write(REG_C_REAL, cr);
		apb_write(REG_C_IMAG, ci);
		apb_write(REG_PLANE_LEFT, left);
		apb_write(REG_PLANE_TOP, top);
		apb_write(REG_STEP_X, sx);
		apb_write(REG_STEP_Y, sy);
		apb_write(REG_MAX_COUNT, mc);
		apb_write(REG_GRID_DIMS, dims);
	endtask

	task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
		@(negedge clk);
		while (src_idle_en && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {col, row};
		do @(posedge clk); while (!s_tready);
		escape_q.push_back(predict_escape(row, col));
	endtask

	// drop valid and let every pending request come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (escape_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_default_config();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd199, 12'd299);
		send_pixel(12'd200, 12'd0);
		send_pixel(12'd0, 12'd300);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd100, 12'd150);
		drain();
	endtask

	task automatic test_limits();
		// pixel 4095,4095 lies outside the grid; pixel 0,0 maps to the plane corner
		set_config(32'h3FFF_FFFF, 32'h4000_0000, 32'd536870912, 32'd536870912,
			32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'd4095, 32'hFF_FFFF);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		drain();
		// zero steps put every pixel on the corner
		set_config(-32'sd536870912, -32'sd536870912, -32'sd1073741824, -32'sd536870912,
			32'd0, 32'd0, 32'd4095, 32'hFF_FFFF);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		drain();
		// z = 2 exactly sits on the circle, escapes after one step
		set_config(32'd0, 32'd0, 32'd536870912, 32'd0, 32'd0, 32'd0, 32'd4095,
			32'hFF_FFFF);
		send_pixel(12'd5, 12'd5);
		drain();
		// z = 0 with c = 0 never escapes: runs to the count limit
		apb_write(REG_PLANE_LEFT, 32'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd2048, 12'd1);
		drain();
		apb_write(REG_MAX_COUNT, 32'd0);
		send_pixel(12'd1, 12'd1);
		drain();
		apb_write(REG_GRID_DIMS, 32'd0);
		send_pixel(12'd0, 12'd0);
		drain();
		apb_write(REG_GRID_DIMS, {8'd0, 12'd10, 12'd0});
		send_pixel(12'd0, 12'd0);
		drain();
		apb_write(REG_GRID_DIMS, {8'd0, 12'd0, 12'd10});
		send_pixel(12'd0, 12'd0);
		drain();
	endtask

	task automatic run_view(input int items, input int mc, input bit idle, input bit press,
		input bit full_grid);
		int h;
		int w;
		int top;
		int left;
		int row;
		int col;
		if (full_grid) begin
			h = 4095;
			w = 4095;
		end else begin
			h = $urandom_range(4, 60);
			w = $urandom_range(4, 60);
		end
		top = $urandom_range(1 << 28, 1 << 29);
		left = -int'($urandom_range(1 << 28, 1 << 29));
		// view about 3 wide, c drawn where the set has structure
		set_config(int'($urandom_range(0, 3 << 27)) - (1 << 28),
			int'($urandom_range(0, 1 << 29)) - (1 << 28), left, top,
			(3 << 28) / w, (2 * top) / h, mc, {8'd0, h[11:0], w[11:0]});
		src_idle_en = idle;
		sink_idle_en = idle;
		for (int i = 0; i < items; i++) begin
			if (press && i == items / 3)
				hold_asked++;
			if ($urandom_range(99) < 85) begin
				row = $urandom_range(0, h - 1);
				col = $urandom_range(0, w - 1);
			end else begin
				row = $urandom_range(0, 4095);
				col = $urandom_range(0, 4095);
			end
			send_pixel(row[11:0], col[11:0]);
		end
		drain();
	endtask

	task automatic test_random_views();
		run_view(300, $urandom_range(8, 48), 1'b1, 1'b0, 1'b0);
		run_view(250, 32, 1'b0, 1'b0, 1'b0);
		run_view(200, 24, 1'b1, 1'b1, 1'b0);
		run_view(120, 255, 1'b1, 1'b0, 1'b0);
		run_view(250, 40, 1'b1, 1'b0, 1'b1);
		run_view(200, $urandom_range(1, 16), 1'b1, 1'b0, 1'b0);
		run_view(200, 63, 1'b1, 1'b1, 1'b0);
	endtask

	// result sink: random stalls, plus long hold-offs on request
	initial begin : sink_proc
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !sink_idle_en || ($urandom_range(99) >= 37);
			end
		end
	end

	always @(posedge clk) begin : check_results
		logic [12:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (escape_q.size() == 0) begin
				report_mismatch($sformatf("escape_count %0d with no pending request",
					$signed(m_tdata[12:0])));
			end else begin
				want = escape_q.pop_front();
				if (m_tdata[12:0] !== want)
					report_mismatch($sformatf("escape_count got %0d expected %0d",
						$signed(m_tdata[12:0]), $signed(want)));
			end
		end
	end

	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		view_cfg.c_real = RST_C_REAL;
		view_cfg.c_imag = RST_C_IMAG;
		view_cfg.plane_left = RST_PLANE_LEFT;
		view_cfg.plane_top = RST_PLANE_TOP;
		view_cfg.step_x = RST_STEP_X;
		view_cfg.step_y = RST_STEP_Y;
		view_cfg.max_count = RST_MAX_COUNT;
		view_cfg.grid_dims = RST_GRID_DIMS;
		orbit_real = 0;
		orbit_imag = 0;
		orbit_count = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;

		test_default_config();
		test_limits();
		test_random_views();

		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
